// ===== hw/rtl/vertical_contact_detector_top_macros.svh =====
// Assertion macros shared by the vertical contact detector RTL.
// Expects clk_i and rst_ni to be visible in the including module.
`ifndef VERTICAL_CONTACT_DETECTOR_TOP_MACROS_SVH
`define VERTICAL_CONTACT_DETECTOR_TOP_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define VCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define VCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vcd_pkg.sv =====
// Package for the vertical contact detector: widths, codes, reset values
// and the command and configuration structs. No dependencies.
`default_nettype none

package vcd_pkg;

  // Quaternion fraction bits and the derived rounding shift.
  localparam int QUAT_FRAC_BITS = 14;
  localparam int SHIFT          = 2 * QUAT_FRAC_BITS;

  localparam int IN_W    = 16;           // every input field
  localparam int TDATA_W = 8 * IN_W;     // eight packed 16-bit fields
  localparam int COEF_W  = 2 * IN_W + 1; // one rotation matrix coefficient
  localparam int MULA_W  = COEF_W + 1;   // multiplier operand A
  localparam int PROD_W  = MULA_W + IN_W;
  localparam int SUM_W   = PROD_W + 2;   // three products plus bias
  localparam int WZ_W    = SUM_W - SHIFT;
  localparam int DIFF_W  = WZ_W + 1;
  localparam int PEAK_W  = 16;
  localparam int GRAV_W  = 15;
  localparam int OUT_W   = 24;           // contact + peak, padded to bytes

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (SHIFT - 1);
  localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

  // Multiply schedule.
  localparam int STEP_W  = 4;
  localparam int NUM_MUL = 11;
  localparam logic [STEP_W-1:0] STEP_XZ   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WY   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_YZ   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_WX   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_WW   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_XX   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_YY   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ZZ   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_CXAX = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CYAY = 4'd9;
  localparam logic [STEP_W-1:0] STEP_CZAZ = 4'd10;

  // Register map.
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DETECT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COMBINED = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRAVITY  = 3'd4;

  localparam logic signed [IN_W-1:0] DETECT_RST   = -16'sd320;
  localparam logic signed [IN_W-1:0] COMBINED_RST = -16'sd240;
  localparam logic signed [IN_W-1:0] RELEASE_RST  = -16'sd160;
  localparam logic [PEAK_W-1:0]      ACCEL_RST    = 16'd10045;
  localparam logic [GRAV_W-1:0]      GRAVITY_RST  = 15'd2511;

  typedef struct packed {
    logic signed [IN_W-1:0] detect;
    logic signed [IN_W-1:0] combined;
    logic signed [IN_W-1:0] release_thr;
    logic [PEAK_W-1:0]      accel;
    logic [GRAV_W-1:0]      gravity;
  } cfg_t;

  typedef struct packed {
    logic              capture;
    logic              mul_en;
    logic [STEP_W-1:0] step;
    logic              diff_en;
    logic              fin_en;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vcd_regs.sv =====
// APB configuration registers of the vertical contact detector.
// Depends on vcd_pkg.
`default_nettype none

module vcd_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [vcd_pkg::APB_AW-1:0] paddr,
  input  wire logic [vcd_pkg::APB_DW-1:0] pwdata,
  output      logic [vcd_pkg::APB_DW-1:0] prdata,
  output      logic                       pready,
  output      vcd_pkg::cfg_t              cfg_o
);

  vcd_pkg::cfg_t                    cfg_q;
  logic [vcd_pkg::REG_IDX_W-1:0]    idx;
  logic                             wr_en;

  assign idx    = paddr[vcd_pkg::APB_AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect      <= vcd_pkg::DETECT_RST;
      cfg_q.combined    <= vcd_pkg::COMBINED_RST;
      cfg_q.release_thr <= vcd_pkg::RELEASE_RST;
      cfg_q.accel       <= vcd_pkg::ACCEL_RST;
      cfg_q.gravity     <= vcd_pkg::GRAVITY_RST;
    end else if (wr_en) begin
      case (idx)
        vcd_pkg::REG_DETECT:   cfg_q.detect      <= pwdata[vcd_pkg::IN_W-1:0];
        vcd_pkg::REG_COMBINED: cfg_q.combined    <= pwdata[vcd_pkg::IN_W-1:0];
        vcd_pkg::REG_RELEASE:  cfg_q.release_thr <= pwdata[vcd_pkg::IN_W-1:0];
        vcd_pkg::REG_ACCEL:    cfg_q.accel       <= pwdata[vcd_pkg::PEAK_W-1:0];
        vcd_pkg::REG_GRAVITY:  cfg_q.gravity     <= pwdata[vcd_pkg::GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      vcd_pkg::REG_DETECT:   prdata = vcd_pkg::APB_DW'(cfg_q.detect);
      vcd_pkg::REG_COMBINED: prdata = vcd_pkg::APB_DW'(cfg_q.combined);
      vcd_pkg::REG_RELEASE:  prdata = vcd_pkg::APB_DW'(cfg_q.release_thr);
      vcd_pkg::REG_ACCEL:    prdata = vcd_pkg::APB_DW'(cfg_q.accel);
      vcd_pkg::REG_GRAVITY:  prdata = vcd_pkg::APB_DW'(cfg_q.gravity);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vcd_datapath.sv =====
// Datapath: shared signed multiplier, coefficient and sum accumulators,
// deviation, peak tracking and the contact flag. Depends on vcd_pkg.
`default_nettype none

module vcd_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vcd_pkg::cmd_t               cmd_i,
  input  wire vcd_pkg::cfg_t               cfg_i,
  input  wire logic [vcd_pkg::TDATA_W-1:0] in_data_i,
  input  wire logic                        in_last_i,
  output      logic                        last_o,
  output      logic [vcd_pkg::OUT_W-1:0]   out_data_o
);

  localparam int IW = vcd_pkg::IN_W;
  localparam int AW = vcd_pkg::MULA_W;
  localparam int CW = vcd_pkg::COEF_W;
  localparam int PW = vcd_pkg::PROD_W;
  localparam int SW = vcd_pkg::SUM_W;
  localparam int DW = vcd_pkg::DIFF_W;
  localparam int KW = vcd_pkg::PEAK_W;

  // Captured item.
  logic signed [IW-1:0] qw_q, qx_q, qy_q, qz_q, ax_q, ay_q, az_q, force_q;
  logic                 last_q;

  // Multiplier and accumulators.
  logic signed [AW-1:0] mul_a;
  logic signed [IW-1:0] mul_b;
  logic signed [PW-1:0] prod_d, prod_q;
  logic                 acc_en_q;
  logic [vcd_pkg::STEP_W-1:0] acc_step_q;
  logic signed [CW-1:0] prod_c;
  logic signed [SW-1:0] prod_s;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic signed [SW-1:0] sum_q;

  // Deviation and decision.
  logic signed [vcd_pkg::WZ_W-1:0] world_z;
  logic signed [DW-1:0] diff_q;
  logic [DW-1:0]        mag;
  logic [KW-1:0]        dev, new_peak, peak_q;
  logic                 contact_q, contact_d;
  logic [KW-1:0]        out_peak_q;
  logic                 out_contact_q;

  function automatic logic signed [AW-1:0] sx(input logic signed [IW-1:0] v);
    sx = {{(AW-IW){v[IW-1]}}, v};
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      qw_q    <= in_data_i[0*IW +: IW];
      qx_q    <= in_data_i[1*IW +: IW];
      qy_q    <= in_data_i[2*IW +: IW];
      qz_q    <= in_data_i[3*IW +: IW];
      ax_q    <= in_data_i[4*IW +: IW];
      ay_q    <= in_data_i[5*IW +: IW];
      az_q    <= in_data_i[6*IW +: IW];
      force_q <= in_data_i[7*IW +: IW];
      last_q  <= in_last_i;
    end
  end

  assign last_o = last_q;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      vcd_pkg::STEP_XZ:   begin mul_a = sx(qx_q); mul_b = qz_q; end
      vcd_pkg::STEP_WY:   begin mul_a = sx(qw_q); mul_b = qy_q; end
      vcd_pkg::STEP_YZ:   begin mul_a = sx(qy_q); mul_b = qz_q; end
      vcd_pkg::STEP_WX:   begin mul_a = sx(qw_q); mul_b = qx_q; end
      vcd_pkg::STEP_WW:   begin mul_a = sx(qw_q); mul_b = qw_q; end
      vcd_pkg::STEP_XX:   begin mul_a = sx(qx_q); mul_b = qx_q; end
      vcd_pkg::STEP_YY:   begin mul_a = sx(qy_q); mul_b = qy_q; end
      vcd_pkg::STEP_ZZ:   begin mul_a = sx(qz_q); mul_b = qz_q; end
      vcd_pkg::STEP_CXAX: begin mul_a = {cx_q, 1'b0}; mul_b = ax_q; end
      vcd_pkg::STEP_CYAY: begin mul_a = {cy_q, 1'b0}; mul_b = ay_q; end
      vcd_pkg::STEP_CZAZ: begin mul_a = {cz_q[CW-1], cz_q}; mul_b = az_q; end
      default:            begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q     <= prod_d;
      acc_step_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= cmd_i.mul_en;
    end
  end

  // Quaternion products fit the coefficient width; the final products are
  // sign extended into the sum.
  assign prod_c = prod_q[CW-1:0];
  assign prod_s = {{(SW-PW){prod_q[PW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (acc_en_q) begin
      case (acc_step_q)
        vcd_pkg::STEP_XZ:   cx_q  <= prod_c;
        vcd_pkg::STEP_WY:   cx_q  <= cx_q - prod_c;
        vcd_pkg::STEP_YZ:   cy_q  <= prod_c;
        vcd_pkg::STEP_WX:   cy_q  <= cy_q + prod_c;
        vcd_pkg::STEP_WW:   cz_q  <= prod_c;
        vcd_pkg::STEP_XX:   cz_q  <= cz_q - prod_c;
        vcd_pkg::STEP_YY:   cz_q  <= cz_q - prod_c;
        vcd_pkg::STEP_ZZ:   cz_q  <= cz_q + prod_c;
        vcd_pkg::STEP_CXAX: sum_q <= vcd_pkg::ROUND_BIAS + prod_s;
        vcd_pkg::STEP_CYAY: sum_q <= sum_q + prod_s;
        vcd_pkg::STEP_CZAZ: sum_q <= sum_q + prod_s;
        default: ;
      endcase
    end
  end

  // The rounding bias is already in the sum, so the shift is a floor.
  assign world_z = sum_q[SW-1:vcd_pkg::SHIFT];

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      diff_q <= {world_z[vcd_pkg::WZ_W-1], world_z}
              - DW'($unsigned(cfg_i.gravity));
    end
  end

  always_comb begin
    mag      = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
    dev      = (|mag[DW-1:KW]) ? vcd_pkg::PEAK_MAX : mag[KW-1:0];
    new_peak = (dev > peak_q) ? dev : peak_q;
    contact_d = contact_q;
    if (!contact_q) begin
      if (force_q < cfg_i.detect) begin
        contact_d = 1'b1;
      end else if ((force_q < cfg_i.combined) && (new_peak > cfg_i.accel)) begin
        contact_d = 1'b1;
      end
    end else if (force_q > cfg_i.release_thr) begin
      contact_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q    <= '0;
      contact_q <= 1'b0;
    end else if (cmd_i.fin_en) begin
      if (last_q) begin
        peak_q    <= '0;
        contact_q <= contact_d;
      end else begin
        peak_q <= new_peak;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_en && last_q) begin
      out_peak_q    <= new_peak;
      out_contact_q <= contact_d;
    end
  end

  assign out_data_o = {{(vcd_pkg::OUT_W-KW-1){1'b0}}, out_peak_q, out_contact_q};

endmodule

`default_nettype wire

// ===== hw/rtl/vcd_ctrl.sv =====
// Controller of the vertical contact detector: sequences the multiply
// schedule and owns both stream handshakes. Depends on vcd_pkg and the macros.
`default_nettype none
`include "vertical_contact_detector_top_macros.svh"

module vcd_ctrl (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output      logic  in_ready_o,
  output      logic  out_valid_o,
  input  wire logic  out_ready_i,
  input  wire logic  last_i,
  output      vcd_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_DIFF  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [vcd_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.step    = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = accept;
        if (accept) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        cnt_d        = cnt_q + vcd_pkg::STEP_W'(1);
        if (cnt_q == vcd_pkg::STEP_W'(vcd_pkg::NUM_MUL - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DIFF;
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        // A window result waits until the output register is free.
        if (!last_i || !out_valid_q || out_ready_i) begin
          cmd_o.fin_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.fin_en && last_i) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `VCD_ASSERT(a_no_overwrite, (cmd_o.fin_en && last_i && out_valid_q) |-> out_ready_i, "pending result overwritten")
  `VCD_ASSERT_NEXT(a_accept_starts, accept, (state_q == ST_MUL) && (cnt_q == '0), "accept did not start schedule")
  `VCD_ASSERT(a_step_range, cmd_o.mul_en |-> (cnt_q < vcd_pkg::STEP_W'(vcd_pkg::NUM_MUL)), "multiply step out of range")
  `VCD_ASSERT(a_valid_source, $rose(out_valid_q) |-> $past(cmd_o.fin_en && last_i), "result without window end")

endmodule

`default_nettype wire

// ===== hw/rtl/vertical_contact_detector_top.sv =====
// Top level of the vertical contact detector: stream ports, APB port and
// the controller, datapath and register instances. Depends on vcd_pkg.
`default_nettype none

// Usage
// The slave stream takes one accelerometer sample per transaction: the
// quaternion, the sensor frame acceleration and the vertical force in tdata,
// and tlast set on the last sample of a window. Samples without tlast update
// the running peak and produce nothing. A sample with tlast produces one
// master stream transaction carrying the updated contact flag and the window
// peak deviation; the peak then restarts at zero.
// Timing: one shared 34 x 16 bit multiplier forms the eleven products of the
// world z component, one per cycle; a drain, deviation and final step follow,
// and s_axis_tready is high again only once that final step is done. The final
// step of a last sample makes the window result valid in an output register,
// so the next sample is accepted while a result waits. If the receiver still
// stalls when the next window ends, that item holds in its final step until
// the register drains. Reset clears the contact flag, the running peak and the
// output valid and loads the register defaults. Configuration is to be written
// over APB while idle by the user; the block itself does not enforce this.
module vertical_contact_detector_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
  // force_vertical, 16 bits each from bit 0 up
  input  wire logic [vcd_pkg::TDATA_W-1:0] s_axis_tdata,
  input  wire logic                        s_axis_tlast,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  // in_contact at bit 0, peak_deviation at bits 16:1, zero padding above
  output      logic [vcd_pkg::OUT_W-1:0]   m_axis_tdata,
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vcd_pkg::APB_AW-1:0]  paddr,
  input  wire logic [vcd_pkg::APB_DW-1:0]  pwdata,
  output      logic [vcd_pkg::APB_DW-1:0]  prdata,
  output      logic                        pready
);

  vcd_pkg::cmd_t cmd;
  vcd_pkg::cfg_t cfg;
  logic          last;

  vcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller sequences the schedule; the datapath holds the sample and every computed value.
  vcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .last_i      (last),
    .cmd_o       (cmd)
  );

  vcd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .last_o     (last),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire
